// ===== rtl/core/scrle_pkg.sv =====
// ----------------------------------------------------------------------------
// scrle_pkg
// Shared types and constants of the signed-count run-length image decoder.
// ----------------------------------------------------------------------------
package scrle_pkg;

  // image limits and stream layout
  localparam int MAX_WIDTH  = 640;
  localparam int MAX_HEIGHT = 480;
  localparam int HDR_BYTES  = 8;
  localparam int PAL_BYTES  = 768;
  localparam int PRE_BYTES  = HDR_BYTES + PAL_BYTES;

  localparam int OFF_W  = 10;  // header and palette byte offset
  localparam int IDX_W  = 19;  // pixel offset and result index
  localparam int VAL_W  = 16;
  localparam int RUN_W  = 16;
  localparam int IMGW_W = 10;
  localparam int IMGH_W = 9;

  // queue between parser and output stage
  localparam int QDEPTH  = 4;
  localparam int QADDR_W = $clog2(QDEPTH);

  localparam int TDATA_W = 56;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_CNT_LO,
    PH_CNT_HI,
    PH_REP_VAL,
    PH_LITERAL,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_PAL,
    KIND_PIX,
    KIND_STATUS
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TOO_SHORT,
    ST_BAD_DIM,
    ST_OVERFLOW,
    ST_MISMATCH
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   index;
    logic [VAL_W-1:0]   value;
    logic [RUN_W-1:0]   run;
    status_t            status;
    logic               last;
  } res_t;

  // results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

// ===== rtl/core/scrle_front.sv =====
// ----------------------------------------------------------------------------
// scrle_front
// Byte parser: tracks header, palette and run phases, builds result entries.
// ----------------------------------------------------------------------------
module scrle_front
  import scrle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       in_fire,
  output logic       push,
  output entry_t     push_entry,
  output phase_t     phase
);

  localparam logic [OFF_W-1:0] HDR_END = OFF_W'(HDR_BYTES - 1);
  localparam logic [OFF_W-1:0] PAL_END = OFF_W'(PRE_BYTES - 1);
  localparam logic [OFF_W-1:0] PRE_END = OFF_W'(PRE_BYTES);

  phase_t             phase_r, phase_s, phase_nxt;
  logic [OFF_W-1:0]   off_r, off_s, off_nxt;
  logic [7:0]         low_r, low_s, low_nxt;
  logic [IMGW_W-1:0]  wid_r, wid_s, wid_nxt;
  logic [IMGH_W-1:0]  hgt_r, hgt_s, hgt_nxt;
  logic [IDX_W-1:0]   tot_r, tot_s, tot_nxt;
  logic [IDX_W-1:0]   pix_r, pix_s, pix_nxt;
  logic [RUN_W-1:0]   rem_r, rem_s, rem_nxt;
  status_t            err_r, err_s, err_nxt;

  logic [15:0]        word;
  logic [1:0]         word_idx;
  logic               dim_w_ok;
  logic               dim_h_ok;
  logic               cnt_rep;
  logic [RUN_W-1:0]   mag;
  logic               fits;
  logic [IDX_W-1:0]   rep_end;
  logic [IDX_W-1:0]   lit_end;
  logic [IDX_W-1:0]   area;
  logic               has0;
  res_t               main_res;
  res_t               stat_res;

  // shared datapath terms
  assign word     = {in_byte, low_r};
  assign word_idx = off_r[2:1];
  assign dim_w_ok = (word >= 16'd1) && (word <= 16'(MAX_WIDTH));
  assign dim_h_ok = (word >= 16'd1) && (word <= 16'(MAX_HEIGHT));
  assign cnt_rep  = (word == 16'd0) || word[15];
  assign mag      = cnt_rep ? (16'd0 - word) : word;
  assign fits     = ({1'b0, pix_r} + {{(IDX_W + 1 - RUN_W){1'b0}}, mag}) <= {1'b0, tot_r};
  assign rep_end  = pix_r + {{(IDX_W - RUN_W){1'b0}}, rem_r};
  assign lit_end  = pix_r + IDX_W'(1);
  assign area     = IDX_W'({{IMGH_W{1'b0}}, wid_r} * {{IMGW_W{1'b0}}, word[IMGH_W-1:0]});
  assign phase    = phase_r;

  // next state for one byte
  always_comb begin
    phase_s = phase_r;
    off_s   = off_r;
    low_s   = low_r;
    wid_s   = wid_r;
    hgt_s   = hgt_r;
    tot_s   = tot_r;
    pix_s   = pix_r;
    rem_s   = rem_r;
    err_s   = err_r;
    case (phase_r)
      PH_HEADER: begin
        if (!off_r[0]) begin
          low_s = in_byte;
        end else if (word_idx == 2'd2) begin
          if (dim_w_ok) begin
            wid_s = word[IMGW_W-1:0];
          end else if (err_r == ST_OK) begin
            err_s = ST_BAD_DIM;
          end
        end else if (word_idx == 2'd3) begin
          if (dim_h_ok) begin
            hgt_s = word[IMGH_W-1:0];
            if (err_r == ST_OK) begin
              tot_s = area;
            end
          end else if (err_r == ST_OK) begin
            err_s = ST_BAD_DIM;
          end
        end
        off_s = off_r + OFF_W'(1);
        if (off_r == HDR_END) begin
          phase_s = PH_PALETTE;
        end
      end
      PH_PALETTE: begin
        off_s = off_r + OFF_W'(1);
        if (off_r == PAL_END) begin
          phase_s = (err_r != ST_OK) ? PH_ERROR : PH_CNT_LO;
        end
      end
      PH_CNT_LO: begin
        low_s   = in_byte;
        phase_s = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        if (!fits) begin
          if (err_r == ST_OK) begin
            err_s = ST_OVERFLOW;
          end
          phase_s = PH_ERROR;
        end else begin
          rem_s   = mag;
          phase_s = cnt_rep ? PH_REP_VAL : PH_LITERAL;
        end
      end
      PH_REP_VAL: begin
        pix_s   = rep_end;
        rem_s   = '0;
        phase_s = (rep_end == tot_r) ? PH_DONE : PH_CNT_LO;
      end
      PH_LITERAL: begin
        pix_s = lit_end;
        rem_s = rem_r - RUN_W'(1);
        if (rem_r == RUN_W'(1)) begin
          phase_s = (lit_end == tot_r) ? PH_DONE : PH_CNT_LO;
        end
      end
      PH_DONE: begin
        if (err_r == ST_OK) begin
          err_s = ST_MISMATCH;
        end
        phase_s = PH_ERROR;
      end
      PH_ERROR: begin
        phase_s = PH_ERROR;
      end
      default: begin
        phase_s = PH_ERROR;
      end
    endcase
  end

  // end of entry returns everything to reset values
  always_comb begin
    if (in_last) begin
      phase_nxt = PH_HEADER;
      off_nxt   = '0;
      low_nxt   = '0;
      wid_nxt   = '0;
      hgt_nxt   = '0;
      tot_nxt   = '0;
      pix_nxt   = '0;
      rem_nxt   = '0;
      err_nxt   = ST_OK;
    end else begin
      phase_nxt = phase_s;
      off_nxt   = off_s;
      low_nxt   = low_s;
      wid_nxt   = wid_s;
      hgt_nxt   = hgt_s;
      tot_nxt   = tot_s;
      pix_nxt   = pix_s;
      rem_nxt   = rem_s;
      err_nxt   = err_s;
    end
  end

  // result built from this byte
  always_comb begin
    has0           = 1'b0;
    main_res       = '0;
    main_res.kind  = KIND_HDR;
    main_res.status = ST_OK;
    case (phase_r)
      PH_HEADER: begin
        has0           = off_r[0];
        main_res.kind  = KIND_HDR;
        main_res.index = {{(IDX_W - 2){1'b0}}, word_idx};
        main_res.value = word;
      end
      PH_PALETTE: begin
        has0           = 1'b1;
        main_res.kind  = KIND_PAL;
        main_res.index = {{(IDX_W - OFF_W){1'b0}}, off_r - OFF_W'(HDR_BYTES)};
        main_res.value = {8'd0, in_byte};
      end
      PH_REP_VAL: begin
        has0           = (rem_r != '0);
        main_res.kind  = KIND_PIX;
        main_res.index = pix_r;
        main_res.value = {8'd0, in_byte};
        main_res.run   = rem_r;
      end
      PH_LITERAL: begin
        has0           = 1'b1;
        main_res.kind  = KIND_PIX;
        main_res.index = pix_r;
        main_res.value = {8'd0, in_byte};
        main_res.run   = RUN_W'(1);
      end
      default: begin
        has0 = 1'b0;
      end
    endcase

    // final status
    stat_res      = '0;
    stat_res.kind = KIND_STATUS;
    stat_res.last = 1'b1;
    if (off_s < PRE_END) begin
      stat_res.status = ST_TOO_SHORT;
    end else if (err_s != ST_OK) begin
      stat_res.status = err_s;
    end else begin
      stat_res.status = (phase_s == PH_DONE) ? ST_OK : ST_MISMATCH;
    end

    push           = in_fire && (has0 || in_last);
    push_entry.two = has0 && in_last;
    push_entry.r0  = has0 ? main_res : stat_res;
    push_entry.r1  = stat_res;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      off_r   <= '0;
      low_r   <= '0;
      wid_r   <= '0;
      hgt_r   <= '0;
      tot_r   <= '0;
      pix_r   <= '0;
      rem_r   <= '0;
      err_r   <= ST_OK;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      low_r   <= low_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      tot_r   <= tot_nxt;
      pix_r   <= pix_nxt;
      rem_r   <= rem_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== rtl/core/scrle_queue.sv =====
// ----------------------------------------------------------------------------
// scrle_queue
// Small register queue of result entries between parser and output stage.
// ----------------------------------------------------------------------------
module scrle_queue
  import scrle_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  localparam logic [QADDR_W-1:0] PTR_LAST = QADDR_W'(QDEPTH - 1);
  localparam logic [QADDR_W:0]   CNT_FULL = (QADDR_W + 1)'(QDEPTH);

  entry_t             mem_r [QDEPTH];
  logic [QADDR_W-1:0] wr_r, wr_nxt;
  logic [QADDR_W-1:0] rd_r, rd_nxt;
  logic [QADDR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + QADDR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + QADDR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QADDR_W + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QADDR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/scrle_back.sv =====
// ----------------------------------------------------------------------------
// scrle_back
// Output stage: splits queued entries into single results, registered output.
// ----------------------------------------------------------------------------
module scrle_back
  import scrle_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  entry_t             head,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);

  logic ov_r, ov_nxt;
  logic sel_r, sel_nxt;
  res_t od_r, od_nxt;
  logic load;

  assign load = !ov_r || out_tready;

  // pick the next result of the head entry
  always_comb begin
    pop     = 1'b0;
    ov_nxt  = ov_r;
    sel_nxt = sel_r;
    od_nxt  = od_r;
    if (load) begin
      if (!empty) begin
        ov_nxt = 1'b1;
        od_nxt = sel_r ? head.r1 : head.r0;
        if (sel_r || !head.two) begin
          pop     = 1'b1;
          sel_nxt = 1'b0;
        end else begin
          sel_nxt = 1'b1;
        end
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      ov_r  <= ov_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  // port packing
  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, od_r.status, od_r.run, od_r.value, od_r.index};
  assign out_tuser  = od_r.kind;
  assign out_tlast  = od_r.last;

endmodule

// ===== rtl/core/signed_count_rle_image_decoder.sv =====
// ----------------------------------------------------------------------------
// signed_count_rle_image_decoder
// Streaming decoder for a run-length coded 8-bit image with 16-bit signed
// counts, one raw byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while its queue has room and reports
// header words, palette bytes, pixel runs and a final status on the last byte
// of an entry. Every byte is parsed as it is accepted; its results go into a
// four-entry queue that an output register drains at one result per cycle
// while the consumer takes them. A byte yields zero, one or two results (two
// only when the last byte also yields a header word, palette byte or pixel run
// of its own), so input runs at one byte per cycle as long as the consumer
// takes results; only the last byte of an entry can add a second result.
// After it the parser is back in header state for the next entry, no gap.
module signed_count_rle_image_decoder
  import scrle_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] in_byte
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [18:0] index, [34:19] value,
                                         // [50:35] run, [53:51] status
  output logic [1:0]         out_tuser,  // [1:0] kind
  output logic               out_tlast
);

  logic   in_fire;
  logic   q_push;
  entry_t q_entry;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_head;
  phase_t fr_phase;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // byte parser
  scrle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .in_fire    (in_fire),
    .push       (q_push),
    .push_entry (q_entry),
    .phase      (fr_phase)
  );

  // result queue
  scrle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // output stage
  scrle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // the parser is back in its header phase after the last byte of an entry
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> fr_phase == PH_HEADER)
    else $error("parser not reset after last byte");

  // the final flag goes with status results and only with them
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == KIND_STATUS)))
    else $error("tlast does not match status kind");

  // a pixel run is never empty
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_PIX) |-> out_tdata[50:35] != 16'd0)
    else $error("empty pixel run emitted");

  // queue is never pushed while full
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("result queue overflow");
`endif

endmodule
